FILE: rtl/promotable_priority_table_top_macros.svh
// Assertion macros shared by the promotable priority table RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PROMOTABLE_PRIORITY_TABLE_TOP_MACROS_SVH
`define PROMOTABLE_PRIORITY_TABLE_TOP_MACROS_SVH

// Same-cycle implication.
`define PPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppt_pkg.sv
// Shared types, codes and defaults for the promotable priority table.
// No dependencies; the interfaces and modules import this package.
package ppt_pkg;

    localparam int OP_W       = 3;
    localparam int ID_W       = 6;
    localparam int PAYLOAD_W  = 64;
    localparam int PRIO_OUT_W = 16;
    localparam int STAMP_W    = 32;

    localparam int DEF_ENTRIES       = 64;
    localparam int DEF_PAYLOAD_BITS  = 64;
    localparam int DEF_PRIORITY_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_PROMOTE = 3'd1,
        OP_GET     = 3'd2,
        OP_GET_MAX = 3'd3,
        OP_POP_MAX = 3'd4,
        OP_IS_VAL  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_ID,
        RD_SCAN,
        RD_BEST
    } rd_src_t;

    typedef enum logic [3:0] {
        OK_ZERO,
        OK_FULL,
        OK_INVALID,
        OK_EMPTY,
        OK_VALID_Q,
        OK_ADDED,
        OK_GOT,
        OK_PROMOTED,
        OK_MAX
    } out_kind_t;

    typedef struct packed {
        logic      load_item;
        logic      rd_en;
        rd_src_t   rd_src;
        logic      idx_inc;
        logic      wr_add;
        logic      wr_promote;
        logic      clr_live;
        logic      out_load;
        out_kind_t out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            live_at_idx;
        logic            idx_last;
        logic            best_found;
        logic            out_free;
    } dp_stat_t;

endpackage

FILE: rtl/ppt_req_if.sv
// Request and response channel interfaces (valid/ready) for the table.
// Depends on ppt_pkg for field widths.
interface ppt_req_if
    import ppt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      entry_id;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, op, entry_id, payload, input ready);
    modport sink   (input valid, op, entry_id, payload, output ready);
endinterface

interface ppt_rsp_if
    import ppt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [ID_W-1:0]       result_id;
    logic [PAYLOAD_W-1:0]  result_payload;
    logic [PRIO_OUT_W-1:0] result_priority;
    logic                  is_present;

    modport source (output valid, status, result_id, result_payload, result_priority,
                    is_present, input ready);
    modport sink   (input valid, status, result_id, result_payload, result_priority,
                    is_present, output ready);
endinterface

FILE: rtl/ppt_dpath.sv
// Datapath: slot memories, live bits, stamp counter, max tracker, result register.
// Depends on ppt_pkg and the assertion macro header.
`include "promotable_priority_table_top_macros.svh"

module ppt_dpath
    import ppt_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [OP_W-1:0]       op,
    input  logic [ID_W-1:0]       entry_id,
    input  logic [PAYLOAD_W-1:0]  payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [ID_W-1:0]       result_id,
    output logic [PAYLOAD_W-1:0]  result_payload,
    output logic [PRIO_OUT_W-1:0] result_priority,
    output logic                  is_present
);
    localparam int IDX_W = $clog2(ENTRIES);

    logic [PAYLOAD_BITS-1:0]  pay_mem   [ENTRIES];
    logic [PRIORITY_BITS-1:0] prio_mem  [ENTRIES];
    logic [STAMP_W-1:0]       stamp_mem [ENTRIES];

    logic [ENTRIES-1:0]       live_reg;
    logic [STAMP_W-1:0]       stamp_ctr_reg;

    logic [OP_W-1:0]          op_reg;
    logic [ID_W-1:0]          id_reg;
    logic [PAYLOAD_BITS-1:0]  pay_reg;
    logic [IDX_W-1:0]         idx_reg;

    logic [PAYLOAD_BITS-1:0]  rd_pay_reg;
    logic [PRIORITY_BITS-1:0] rd_prio_reg;
    logic [STAMP_W-1:0]       rd_stamp_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     rd_live_reg;
    logic                     scan_q_reg;

    logic                     best_found_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic [STAMP_W-1:0]       best_age_reg;
    logic [IDX_W-1:0]         best_idx_reg;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [ID_W-1:0]          rid_reg;
    logic [PAYLOAD_W-1:0]     rpay_reg;
    logic [PRIO_OUT_W-1:0]    rprio_reg;
    logic                     present_reg;

    logic [IDX_W-1:0]         id_idx;
    logic                     id_in_range;
    logic                     id_ok;
    logic [IDX_W-1:0]         rd_addr;
    logic [PRIORITY_BITS-1:0] prio_new;
    logic [STAMP_W-1:0]       age;
    logic                     better;

    assign id_idx      = IDX_W'(id_reg);
    assign id_in_range = (32'(id_reg) < 32'(ENTRIES));
    assign id_ok       = id_in_range && live_reg[id_idx];
    assign prio_new    = (rd_prio_reg == '1) ? rd_prio_reg : rd_prio_reg + PRIORITY_BITS'(1);
    assign age         = stamp_ctr_reg - rd_stamp_reg;
    assign better      = rd_live_reg && (!best_found_reg || (rd_prio_reg > best_prio_reg) ||
                         ((rd_prio_reg == best_prio_reg) && (age < best_age_reg)));

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_ID:   rd_addr = id_idx;
            RD_SCAN: rd_addr = idx_reg;
            RD_BEST: rd_addr = best_idx_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    assign stat.op          = op_reg;
    assign stat.id_ok       = id_ok;
    assign stat.live_at_idx = live_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == IDX_W'(ENTRIES - 1));
    assign stat.best_found  = best_found_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Item registers and scan index
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= op;
            id_reg  <= entry_id;
            pay_reg <= PAYLOAD_BITS'(payload);
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_add)
        begin
            pay_mem[idx_reg]   <= pay_reg;
            stamp_mem[idx_reg] <= stamp_ctr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_add)
        begin
            prio_mem[idx_reg] <= '0;
        end
        else if (cmd.wr_promote)
        begin
            prio_mem[id_idx] <= prio_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_pay_reg   <= pay_mem[rd_addr];
            rd_prio_reg  <= prio_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
            rd_live_reg  <= live_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            stamp_ctr_reg <= '0;
        end
        else
        begin
            if (cmd.wr_add)
            begin
                live_reg[idx_reg] <= 1'b1;
                stamp_ctr_reg     <= stamp_ctr_reg + STAMP_W'(1);
            end
            else if (cmd.clr_live)
            begin
                live_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // Running max over the slot scan, one slot per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_q_reg     <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            scan_q_reg <= cmd.rd_en && (cmd.rd_src == RD_SCAN);
            if (cmd.load_item)
            begin
                best_found_reg <= 1'b0;
            end
            else if (scan_q_reg && better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_q_reg && better)
        begin
            best_prio_reg <= rd_prio_reg;
            best_age_reg  <= age;
            best_idx_reg  <= rd_idx_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg  <= ST_OK;
            rid_reg     <= '0;
            rpay_reg    <= '0;
            rprio_reg   <= '0;
            present_reg <= 1'b0;
            unique case (cmd.out_kind)
                OK_ZERO:
                begin
                end
                OK_FULL:    status_reg <= ST_FULL;
                OK_EMPTY:   status_reg <= ST_EMPTY;
                OK_INVALID:
                begin
                    status_reg <= ST_INVALID;
                    rid_reg    <= id_reg;
                end
                OK_VALID_Q:
                begin
                    rid_reg     <= id_reg;
                    present_reg <= id_ok;
                end
                OK_ADDED:
                begin
                    rid_reg  <= ID_W'(idx_reg);
                    rpay_reg <= PAYLOAD_W'(pay_reg);
                end
                OK_GOT:
                begin
                    rid_reg   <= id_reg;
                    rpay_reg  <= PAYLOAD_W'(rd_pay_reg);
                    rprio_reg <= PRIO_OUT_W'(rd_prio_reg);
                end
                OK_PROMOTED:
                begin
                    rid_reg   <= id_reg;
                    rpay_reg  <= PAYLOAD_W'(rd_pay_reg);
                    rprio_reg <= PRIO_OUT_W'(prio_new);
                end
                OK_MAX:
                begin
                    rid_reg   <= ID_W'(best_idx_reg);
                    rpay_reg  <= PAYLOAD_W'(rd_pay_reg);
                    rprio_reg <= PRIO_OUT_W'(rd_prio_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign result_id       = rid_reg;
    assign result_payload  = rpay_reg;
    assign result_priority = rprio_reg;
    assign is_present      = present_reg;

    `PPT_ASSERT_NEXT(a_add_sets_live, cmd.wr_add, live_reg[$past(idx_reg)], "add left slot dead")
    `PPT_ASSERT_NEXT(a_ctr_add_only, !cmd.wr_add, $stable(stamp_ctr_reg), "stamp moved without add")
    `PPT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result overwritten")
    `PPT_ASSERT_NOW(a_pop_has_max, cmd.clr_live, best_found_reg, "pop without a max entry")

endmodule

FILE: rtl/ppt_ctrl.sv
// Controller state machine: sequences add scan, id access and max scan.
// Depends on ppt_pkg; drives the datapath through dp_cmd_t.
module ppt_ctrl
    import ppt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_SCAN,
        S_ACC_WAIT,
        S_MAX_SCAN,
        S_MAX_DRAIN,
        S_MAX_PICK,
        S_MAX_WAIT,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_src = RD_SCAN;
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                priority case (stat.op)
                    OP_ADD:
                    begin
                        state_next = S_ADD_SCAN;
                    end
                    OP_PROMOTE, OP_GET:
                    begin
                        if (stat.id_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RD_ID;
                            state_next = S_ACC_WAIT;
                        end
                        else
                        begin
                            kind_next = OK_INVALID;
                        end
                    end
                    OP_GET_MAX, OP_POP_MAX:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.idx_inc = 1'b1;
                        state_next  = S_MAX_SCAN;
                    end
                    OP_IS_VAL:
                    begin
                        kind_next = OK_VALID_Q;
                    end
                    default:
                    begin
                        kind_next = OK_ZERO;
                    end
                endcase
            end
            S_ADD_SCAN:
            begin
                if (!stat.live_at_idx)
                begin
                    cmd.wr_add = 1'b1;
                    kind_next  = OK_ADDED;
                    state_next = S_FINISH;
                end
                else if (stat.idx_last)
                begin
                    kind_next  = OK_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_ACC_WAIT:
            begin
                if (stat.op == OP_PROMOTE)
                begin
                    cmd.wr_promote = 1'b1;
                    kind_next      = OK_PROMOTED;
                end
                else
                begin
                    kind_next = OK_GOT;
                end
                state_next = S_FINISH;
            end
            S_MAX_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_MAX_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_MAX_DRAIN:
            begin
                state_next = S_MAX_PICK;
            end
            S_MAX_PICK:
            begin
                if (stat.best_found)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_BEST;
                    state_next = S_MAX_WAIT;
                end
                else
                begin
                    kind_next  = OK_EMPTY;
                    state_next = S_FINISH;
                end
            end
            S_MAX_WAIT:
            begin
                cmd.clr_live = (stat.op == OP_POP_MAX);
                kind_next    = OK_MAX;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= OK_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

FILE: rtl/promotable_priority_table_top.sv
// Promotable priority table: one operation per request, one response each.
// Add walks the live bits one slot a cycle until it finds a free slot or
// reaches the last one; get-max and pop-max scan every slot through the
// single read port of the slot memories, one slot a cycle. One request is
// in flight at a time; a new one is taken while the previous response
// still waits in the output register. Depends on ppt_pkg and the channel
// interfaces.
module promotable_priority_table_top
    import ppt_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
)
(
    input logic      clk,
    input logic      rst_n,
    ppt_req_if.sink  req,
    ppt_rsp_if.source rsp
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppt_dpath #(
        .ENTRIES       (ENTRIES),
        .PAYLOAD_BITS  (PAYLOAD_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (req.op),
        .entry_id        (req.entry_id),
        .payload         (req.payload),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .status          (rsp.status),
        .result_id       (rsp.result_id),
        .result_payload  (rsp.result_payload),
        .result_priority (rsp.result_priority),
        .is_present      (rsp.is_present)
    );

endmodule
